// ----- hdl/prime_coordinate_scanner_core_macros.svh -----
// Assertion macros used by the scanner core RTL
`ifndef PRIME_COORDINATE_SCANNER_CORE_MACROS_SVH
`define PRIME_COORDINATE_SCANNER_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define PCS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define PCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/pcs_pkg.sv -----
// Shared constants and types for the prime coordinate scanner
package pcs_pkg;

  localparam int VALUE_BITS = 16;
  localparam int DIV_BITS   = VALUE_BITS / 2 + 1;
  localparam int SQ_BITS    = 2 * DIV_BITS;
  localparam int CNT_BITS   = $clog2(VALUE_BITS);
  localparam int POS_BITS   = 16;
  localparam int FIELD_BITS = 16;
  localparam int ADDR_BITS  = 3;
  localparam int DATA_BITS  = 32;

  localparam logic [POS_BITS-1:0] ROW_LENGTH_RESET = POS_BITS'(5000);
  localparam logic [ADDR_BITS-1:0] REG_ROW_LENGTH  = ADDR_BITS'(0);

  typedef struct packed {
    logic                  start;
    logic [VALUE_BITS-1:0] dividend;
    logic [DIV_BITS-1:0]   divisor;
  } pcs_div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic rem_zero;
  } pcs_div_rsp_t;

  typedef struct packed {
    logic [POS_BITS-1:0] row;
    logic [POS_BITS-1:0] column;
  } pcs_pos_t;

endpackage

// ----- hdl/prime_coordinate_scanner_core.sv -----
// Top level: trial-division prime test with row/column tagging of each item
// Odd values of 3 or more are divided by each odd trial divisor d with d*d <= value
// until one divides; 2 is prime, values below 2 and even values are not. Non-primes give no result.
// One item at a time: in_stall holds new items until the block returns to idle, which takes
// longer while a result waits on out_stall. Reset: synchronous active-low rst_n, row_length 5000.
module prime_coordinate_scanner_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [pcs_pkg::FIELD_BITS-1:0]  in_value,
  input  logic                            in_first,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [pcs_pkg::POS_BITS-1:0]    out_row,
  output logic [pcs_pkg::POS_BITS-1:0]    out_column,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pcs_pkg::ADDR_BITS-1:0]   paddr,
  input  logic [pcs_pkg::DATA_BITS-1:0]   pwdata,
  output logic [pcs_pkg::DATA_BITS-1:0]   prdata,
  output logic                            pready
);
  import pcs_pkg::*;
  `include "prime_coordinate_scanner_core_macros.svh"

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_FINISH
  } state_t;

  state_t                state_r, state_nxt;
  logic [POS_BITS-1:0]   row_length_r;
  logic [VALUE_BITS-1:0] cand_r, cand_nxt;
  logic [DIV_BITS-1:0]   div_r, div_nxt;
  logic [SQ_BITS-1:0]    sq_r, sq_nxt;
  logic                  prime_r, prime_nxt;
  logic [POS_BITS-1:0]   item_row_r, item_row_nxt;
  logic [POS_BITS-1:0]   item_col_r, item_col_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [POS_BITS-1:0]   out_row_r, out_row_nxt;
  logic [POS_BITS-1:0]   out_col_r, out_col_nxt;
  logic                  div_start;

  logic                  accept;
  logic [VALUE_BITS-1:0] in_n;
  logic                  cfg_write;
  pcs_div_req_t          div_req;
  pcs_div_rsp_t          div_rsp;
  pcs_pos_t              pos;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign in_n      = VALUE_BITS'(in_value);
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[ADDR_BITS-1] == REG_ROW_LENGTH[ADDR_BITS-1]) ?
                     DATA_BITS'(row_length_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_length_r <= ROW_LENGTH_RESET;
    end else if (cfg_write && (paddr[ADDR_BITS-1] == REG_ROW_LENGTH[ADDR_BITS-1])) begin
      row_length_r <= pwdata[POS_BITS-1:0];
    end
  end

  pcs_position u_position (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (accept),
    .first      (in_first),
    .row_length (row_length_r),
    .pos        (pos)
  );

  assign div_req.start    = div_start;
  assign div_req.dividend = cand_r;
  assign div_req.divisor  = div_r;

  pcs_serial_mod u_serial_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_comb begin
    state_nxt     = state_r;
    cand_nxt      = cand_r;
    div_nxt       = div_r;
    sq_nxt        = sq_r;
    prime_nxt     = prime_r;
    item_row_nxt  = item_row_r;
    item_col_nxt  = item_col_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    div_start     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cand_nxt     = in_n;
          div_nxt      = DIV_BITS'(3);
          sq_nxt       = SQ_BITS'(9);
          item_row_nxt = pos.row;
          item_col_nxt = pos.column;
          if (in_n < VALUE_BITS'(2)) begin
            prime_nxt = 1'b0;
            state_nxt = S_FINISH;
          end else if (in_n == VALUE_BITS'(2)) begin
            prime_nxt = 1'b1;
            state_nxt = S_FINISH;
          end else if (!in_n[0]) begin
            prime_nxt = 1'b0;
            state_nxt = S_FINISH;
          end else begin
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (sq_r > SQ_BITS'(cand_r)) begin
          prime_nxt = 1'b1;
          state_nxt = S_FINISH;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          if (div_rsp.rem_zero) begin
            prime_nxt = 1'b0;
            state_nxt = S_FINISH;
          end else begin
            div_nxt   = div_r + DIV_BITS'(2);
            sq_nxt    = sq_r + SQ_BITS'({div_r, 2'b00}) + SQ_BITS'(4);
            state_nxt = S_CHECK;
          end
        end
      end
      S_FINISH: begin
        if (!prime_r) begin
          state_nxt = S_IDLE;
        end else if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_row_nxt   = item_row_r;
          out_col_nxt   = item_col_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cand_r      <= '0;
      div_r       <= DIV_BITS'(3);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cand_r      <= cand_nxt;
      div_r       <= div_nxt;
    end
    sq_r       <= sq_nxt;
    prime_r    <= prime_nxt;
    item_row_r <= item_row_nxt;
    item_col_r <= item_col_nxt;
    out_row_r  <= out_row_nxt;
    out_col_r  <= out_col_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_row    = out_row_r;
  assign out_column = out_col_r;

  `PCS_ASSERT_NEXT(a_busy_after_accept, accept, in_stall, "item accepted but block not busy")
  `PCS_ASSERT_NOW(a_done_in_div, div_rsp.done, state_r == S_DIV, "remainder done outside divide")
  `PCS_ASSERT_NOW(a_check_unit_idle, state_r == S_CHECK, !div_rsp.busy, "remainder unit busy in check")
  `PCS_ASSERT_NEXT(a_load_from_finish, !out_valid_r && out_valid_nxt, $past(state_r) == S_FINISH && prime_r, "result loaded outside finish")

endmodule

// ----- hdl/pcs_serial_mod.sv -----
// Bit-serial restoring remainder unit, one dividend bit per cycle
module pcs_serial_mod (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pcs_pkg::pcs_div_req_t req,
  output pcs_pkg::pcs_div_rsp_t rsp
);
  import pcs_pkg::*;

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [CNT_BITS-1:0]   cnt_r, cnt_nxt;
  logic [VALUE_BITS-1:0] num_r, num_nxt;
  logic [DIV_BITS-1:0]   den_r, den_nxt;
  logic [DIV_BITS-1:0]   rem_r, rem_nxt;
  logic [DIV_BITS:0]     trial;
  logic [DIV_BITS:0]     diff;

  assign trial = {rem_r, num_r[VALUE_BITS-1]};
  assign diff  = trial - {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    if (busy_r) begin
      num_nxt = num_r << 1;
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = diff[DIV_BITS-1:0];
      end else begin
        rem_nxt = trial[DIV_BITS-1:0];
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_BITS'(VALUE_BITS - 1);
      num_nxt  = req.dividend;
      den_nxt  = req.divisor;
      rem_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.rem_zero = (rem_r == '0);

endmodule

// ----- hdl/pcs_position.sv -----
// Row and column counters with row-length wrap and saturating row
module pcs_position (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          advance,
  input  logic                          first,
  input  logic [pcs_pkg::POS_BITS-1:0]  row_length,
  output pcs_pkg::pcs_pos_t             pos
);
  import pcs_pkg::*;

  logic [POS_BITS-1:0] row_r, row_nxt;
  logic [POS_BITS-1:0] col_r, col_nxt;
  logic [POS_BITS-1:0] base_row;
  logic [POS_BITS-1:0] base_col;
  logic [POS_BITS:0]   next_col;
  logic                wrap;

  assign base_row = first ? '0 : row_r;
  assign base_col = first ? '0 : col_r;
  assign next_col = {1'b0, base_col} + 1'b1;
  assign wrap     = next_col[POS_BITS] ||
                    ((row_length != '0) && (next_col >= {1'b0, row_length}));

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (advance) begin
      if (wrap) begin
        col_nxt = '0;
        row_nxt = (base_row == '1) ? base_row : base_row + 1'b1;
      end else begin
        col_nxt = next_col[POS_BITS-1:0];
        row_nxt = base_row;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  assign pos.row    = base_row;
  assign pos.column = base_col;

endmodule
